### rtl/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int SIZE_W   = 16;  // requested byte count
  localparam int ADDR_W   = 15;  // user byte address
  localparam int CFG_W    = 13;  // arena size register
  localparam int WORDS_W  = 17;  // rounded word count, wide enough for size + WORD_BYTES - 1

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

### rtl/ffa_hdr_mem.sv
`timescale 1ns / 1ps

module ffa_hdr_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 13
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/ffa_size_words.sv
`timescale 1ns / 1ps

module ffa_size_words #(
  parameter int WORD_BYTES = 8
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic [ffa_pkg::SIZE_W-1:0]   size_bytes,
  output logic [ffa_pkg::WORDS_W-1:0]  words
);

  // ceil(bytes / WORD_BYTES) as floor((bytes + WORD_BYTES - 1) / WORD_BYTES), done by
  // multiplying with a rounded-up reciprocal; exact for every dividend below 2**WORDS_W
  localparam int RND_W   = ffa_pkg::WORDS_W;
  localparam int SHIFT   = RND_W + $clog2(WORD_BYTES);
  localparam int RECIP   = ((1 << SHIFT) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int RECIP_W = RND_W + 2;
  localparam int PROD_W  = RND_W + RECIP_W;

  logic [RND_W-1:0]  rounded;
  logic [PROD_W-1:0] prod_r;
  logic [RND_W-1:0]  quot;

  assign rounded = RND_W'(size_bytes) + RND_W'(WORD_BYTES - 1);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(rounded) * PROD_W'(RECIP_W'(RECIP));
    end
  end

  assign quot = RND_W'(prod_r >> SHIFT);

  // a zero-byte request is served as one word
  assign words = (quot == '0) ? RND_W'(1) : quot;

endmodule

### rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps

// First-fit allocator over an arena of words kept as an implicit list of headed
// blocks. Each block is HEADER_WORDS header words plus a data area; the header
// entry at the block's first word holds its data size in words and a free flag.
// Send one word per request on the in_ channel: in_req_type 0 allocates
// in_size_bytes (rounded up to whole words, zero treated as one word), 1 frees the
// block whose data area starts at byte in_user_address. Each request returns one
// word on the out_ channel with out_status (0 ok, 1 larger than the arena, 2 no
// free block fits, 3 no data area at that address) and out_granted_address, the
// byte offset of the granted data area, zero unless an allocate succeeded.
// An allocate walks blocks from word 0 and takes the first free one that is big
// enough, splitting off a free tail when a header plus one data word remains. A free
// marks the block free and absorbs every free block that directly follows it,
// stopping at the arena end. Writing cfg_wdata with cfg_we sets the arena size
// (saturated to HEADER_WORDS+1 .. ARENA_MAX_WORDS) and reinitializes the arena to
// one free block; write it only while no request is in flight.
// Timing: the walk reads one header per cycle from the header memory (one read
// and one write port, registered read). An allocate loads the rounding product on
// accept, takes the word count in S_DIV, visits blocks in S_WALK, writes the
// allocated header in S_HEAD when it splits and posts the result in S_OUT. A free
// visits blocks in S_WALK, absorbs free followers in S_MERGE and posts in S_OUT,
// which waits while the output register is full. After reset and after every arena
// write the block writes the first header in S_INIT before in_ready rises. The next
// request is taken while the previous result still waits in the output register.

module first_fit_block_allocator #(
  parameter int ARENA_MAX_WORDS = 4096,
  parameter int WORD_BYTES      = 8,
  parameter int HEADER_WORDS    = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [ffa_pkg::CFG_W-1:0]    cfg_wdata,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [ffa_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [ffa_pkg::ADDR_W-1:0]   in_user_address,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [ffa_pkg::ADDR_W-1:0]   out_granted_address
);

  localparam int OFF_W  = $clog2(ARENA_MAX_WORDS);      // header memory index
  localparam int CNT_W  = $clog2(ARENA_MAX_WORDS + 1);  // holds the arena size itself
  localparam int SZ_W   = OFF_W;                        // block data size
  localparam int ENT_W  = SZ_W + 1;                     // {free, size}
  localparam int SUM_W  = CNT_W + 2;                    // offset arithmetic headroom
  localparam int BA_W   = (CNT_W + 6 > 16) ? CNT_W + 6 : 16;
  localparam int CMP_W  = (CNT_W > ffa_pkg::CFG_W) ? CNT_W : ffa_pkg::CFG_W;
  localparam int WCMP_W = (CNT_W > ffa_pkg::WORDS_W) ? CNT_W : ffa_pkg::WORDS_W;

  localparam logic [CNT_W-1:0] ARENA_RST =
    CNT_W'((ARENA_MAX_WORDS < 4096) ? ARENA_MAX_WORDS : 4096);
  localparam logic [SUM_W-1:0] HDR = SUM_W'(HEADER_WORDS);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_WALK,
    S_HEAD,
    S_MERGE,
    S_OUT
  } state_t;

  state_t                      state_r;
  logic [CNT_W-1:0]            arena_r;
  logic                        req_free_r;
  logic [ffa_pkg::ADDR_W-1:0]  addr_r;
  logic [CNT_W-1:0]            words_r;
  logic [CNT_W-1:0]            off_r;
  logic [SZ_W-1:0]             acc_r;
  ffa_pkg::status_t            res_status_r;
  logic [ffa_pkg::ADDR_W-1:0]  res_addr_r;
  logic                        out_valid_r;
  ffa_pkg::status_t            out_status_r;
  logic [ffa_pkg::ADDR_W-1:0]  out_addr_r;

  logic                        mem_we;
  logic [OFF_W-1:0]            mem_waddr;
  logic [ENT_W-1:0]            mem_wdata;
  logic [OFF_W-1:0]            mem_raddr;
  logic [ENT_W-1:0]            mem_rdata;

  logic                        sw_load;
  logic [ffa_pkg::WORDS_W-1:0] sw_words;

  logic                        rd_free;
  logic [SZ_W-1:0]             rd_size;
  logic [SUM_W-1:0]            walk_nxt;
  logic                        walk_nxt_fits;
  logic [BA_W-1:0]             blk_byte;
  logic                        addr_hit;
  logic                        fit_hit;
  logic                        split;
  logic [SUM_W-1:0]            tail_off;
  logic [SZ_W-1:0]             tail_size;
  logic [SZ_W-1:0]             merge_acc;
  logic [SUM_W-1:0]            merge_nxt;
  logic                        merge_nxt_fits;
  logic                        too_large;
  logic [CMP_W-1:0]            cfg_ext;
  logic [CNT_W-1:0]            cfg_sat;
  logic                        accept;
  logic                        out_free;

  function automatic logic fits(input logic [SUM_W-1:0] off, input logic [CNT_W-1:0] arena);
    return (off + HDR) <= SUM_W'(arena);
  endfunction

  ffa_hdr_mem #(
    .DEPTH  (ARENA_MAX_WORDS),
    .DATA_W (ENT_W)
  ) u_hdr_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  ffa_size_words #(
    .WORD_BYTES (WORD_BYTES)
  ) u_size_words (
    .clk        (clk),
    .load       (sw_load),
    .size_bytes (in_size_bytes),
    .words      (sw_words)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign sw_load  = accept && (in_req_type == ffa_pkg::REQ_ALLOC);
  assign out_free = !out_valid_r || out_ready;

  assign rd_free = mem_rdata[SZ_W];
  assign rd_size = mem_rdata[SZ_W-1:0];

  // next block after the one being read during the walk
  assign walk_nxt      = SUM_W'(off_r) + HDR + SUM_W'(rd_size);
  assign walk_nxt_fits = fits(walk_nxt, arena_r);

  assign blk_byte = (BA_W'(off_r) + BA_W'(HEADER_WORDS)) * BA_W'(WORD_BYTES);
  assign addr_hit = (blk_byte == BA_W'(addr_r));

  assign fit_hit   = rd_free && (SUM_W'(rd_size) >= SUM_W'(words_r));
  assign split     = SUM_W'(rd_size) >= SUM_W'(words_r) + HDR + SUM_W'(1);
  assign tail_off  = SUM_W'(off_r) + HDR + SUM_W'(words_r);
  assign tail_size = SZ_W'(SUM_W'(rd_size) - SUM_W'(words_r) - HDR);

  // merge: absorb the block just read into the accumulated size
  assign merge_acc      = SZ_W'(SUM_W'(acc_r) + HDR + SUM_W'(rd_size));
  assign merge_nxt      = SUM_W'(off_r) + HDR + SUM_W'(merge_acc);
  assign merge_nxt_fits = fits(merge_nxt, arena_r);

  assign too_large = WCMP_W'(sw_words) > WCMP_W'(arena_r);

  // saturate the arena size write
  assign cfg_ext = CMP_W'(cfg_wdata);
  always_comb begin
    priority if (cfg_ext < CMP_W'(HEADER_WORDS + 1)) begin
      cfg_sat = CNT_W'(HEADER_WORDS + 1);
    end else if (cfg_ext > CMP_W'(ARENA_MAX_WORDS)) begin
      cfg_sat = CNT_W'(ARENA_MAX_WORDS);
    end else begin
      cfg_sat = CNT_W'(cfg_ext);
    end
  end

  // header memory access
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = OFF_W'(off_r);
    mem_wdata = {1'b0, rd_size};
    mem_raddr = '0;
    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {1'b1, SZ_W'(SUM_W'(arena_r) - HDR)};
      end
      S_WALK: begin
        if (req_free_r) begin
          if (addr_hit) begin
            if (walk_nxt_fits) begin
              mem_raddr = OFF_W'(walk_nxt);
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, rd_size};
            end
          end else begin
            mem_raddr = OFF_W'(walk_nxt);
          end
        end else begin
          if (fit_hit) begin
            mem_we = 1'b1;
            if (split) begin
              mem_waddr = OFF_W'(tail_off);
              mem_wdata = {1'b1, tail_size};
            end else begin
              mem_wdata = {1'b0, rd_size};
            end
          end else begin
            mem_raddr = OFF_W'(walk_nxt);
          end
        end
      end
      S_HEAD: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, SZ_W'(words_r)};
      end
      S_MERGE: begin
        if (rd_free) begin
          if (merge_nxt_fits) begin
            mem_raddr = OFF_W'(merge_nxt);
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, merge_acc};
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, acc_r};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      arena_r     <= ARENA_RST;
      out_valid_r <= 1'b0;
    end else begin
      // load the result word when the register is free, drop it once taken
      if (state_r == S_OUT && out_free && !cfg_we) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        // arena write reinitializes the list
        arena_r <= cfg_sat;
        state_r <= S_INIT;
      end else begin
        unique case (state_r)
          S_INIT: begin
            state_r <= S_IDLE;
          end
          S_IDLE: begin
            if (accept) begin
              req_free_r <= (in_req_type == ffa_pkg::REQ_FREE);
              addr_r     <= in_user_address;
              off_r      <= '0;
              state_r    <= (in_req_type == ffa_pkg::REQ_FREE) ? S_WALK : S_DIV;
            end
          end
          S_DIV: begin
            words_r <= CNT_W'(sw_words);
            if (too_large) begin
              res_status_r <= ffa_pkg::ST_TOO_LARGE;
              res_addr_r   <= '0;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_WALK;
            end
          end
          S_WALK: begin
            if (req_free_r) begin
              if (addr_hit) begin
                acc_r        <= rd_size;
                res_status_r <= ffa_pkg::ST_OK;
                res_addr_r   <= '0;
                state_r      <= walk_nxt_fits ? S_MERGE : S_OUT;
              end else if (walk_nxt_fits) begin
                off_r <= CNT_W'(walk_nxt);
              end else begin
                res_status_r <= ffa_pkg::ST_NOT_FOUND;
                res_addr_r   <= '0;
                state_r      <= S_OUT;
              end
            end else begin
              if (fit_hit) begin
                res_status_r <= ffa_pkg::ST_OK;
                res_addr_r   <= blk_byte[ffa_pkg::ADDR_W-1:0];
                state_r      <= split ? S_HEAD : S_OUT;
              end else if (walk_nxt_fits) begin
                off_r <= CNT_W'(walk_nxt);
              end else begin
                res_status_r <= ffa_pkg::ST_NO_FIT;
                res_addr_r   <= '0;
                state_r      <= S_OUT;
              end
            end
          end
          S_HEAD: begin
            state_r <= S_OUT;
          end
          S_MERGE: begin
            // advance while the following block is free and inside the arena
            if (rd_free && merge_nxt_fits) begin
              acc_r <= merge_acc;
            end else begin
              state_r <= S_OUT;
            end
          end
          S_OUT: begin
            if (out_free) begin
              out_status_r <= res_status_r;
              out_addr_r   <= res_addr_r;
              state_r      <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_INIT;
          end
        endcase
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;

endmodule
